// ----- rtl/bessel_j0_power_series_assert.svh -----
// Assertion macros shared by the J0 series block.
`ifndef BESSEL_J0_POWER_SERIES_ASSERT_SVH
`define BESSEL_J0_POWER_SERIES_ASSERT_SVH

// Same-cycle implication, reported by label and message.
`define BJ0_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication.
`define BJ0_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ----- rtl/bj0_pkg.sv -----
// Package: widths, limits and the item record of the J0 series chain.
package bj0_pkg;

  localparam int NUM_TERMS = 30;
  localparam int NUM_CELLS = NUM_TERMS - 1;
  localparam int X_W = 21;
  localparam int Q_W = 2 * X_W;
  localparam int MAG_W = 57;
  localparam int SUM_W = 58;
  localparam int R_W = 33;
  localparam int OUT_W = 36;

  localparam logic [MAG_W-1:0] INNER_MAX = {MAG_W{1'b1}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic                    valid;
    logic [Q_W-1:0]          q;
    logic [MAG_W-1:0]        mag;
    logic signed [SUM_W-1:0] sum;
    logic                    clip;
  } bj0_item_t;

endpackage

// ----- rtl/bj0_cell.sv -----
// One series term cell: next term magnitude and running sum, five stages.
module bj0_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [bj0_pkg::R_W-1:0]   recip,
  input  logic                      odd,
  input  bj0_pkg::bj0_item_t        din,
  output bj0_pkg::bj0_item_t        dout
);
  import bj0_pkg::*;

  bj0_item_t st1, st2, st3, st4, st5;
  bj0_item_t st4_next, st5_next;
  logic [X_W+R_W-1:0] pa, pb;
  logic [Q_W-1:0] f;
  logic [49:0] p00, p01;
  logic [48:0] p10, p11;

  logic [X_W+R_W+X_W:0] fsum;
  logic [99:0] msum;
  logic [65:0] mres;
  logic [MAG_W-1:0] mag_next;
  logic clip_next;
  logic signed [SUM_W:0] tsum;
  logic signed [SUM_W-1:0] sum_next;
  logic sclip;

  always_comb begin
    fsum = {{(X_W+1){1'b0}}, pa} + {1'b0, pb, {X_W{1'b0}}} + (76'd1 << 31);
    msum = {50'd0, p00} + {29'd0, p01, 21'd0} + {22'd0, p10, 29'd0} + {1'b0, p11, 50'd0}
           + (100'd1 << 33);
    mres = msum[99:34];
    if (mres > {9'd0, INNER_MAX}) begin
      mag_next = INNER_MAX;
      clip_next = 1'b1;
    end else begin
      mag_next = mres[MAG_W-1:0];
      clip_next = 1'b0;
    end
    if (odd) begin
      tsum = {st4.sum[SUM_W-1], st4.sum} - {2'b00, st4.mag};
    end else begin
      tsum = {st4.sum[SUM_W-1], st4.sum} + {2'b00, st4.mag};
    end
    if (tsum > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
      sum_next = SUM_MAX;
      sclip = 1'b1;
    end else if (tsum < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
      sum_next = SUM_MIN;
      sclip = 1'b1;
    end else begin
      sum_next = tsum[SUM_W-1:0];
      sclip = 1'b0;
    end
    st4_next = st3;
    st4_next.mag = mag_next;
    st4_next.clip = st3.clip | clip_next;
    st5_next = st4;
    st5_next.sum = sum_next;
    st5_next.clip = st4.clip | sclip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid <= 1'b0;
      st2.valid <= 1'b0;
      st3.valid <= 1'b0;
      st4.valid <= 1'b0;
      st5.valid <= 1'b0;
    end else if (en) begin
      st1 <= din;
      pa <= din.q[X_W-1:0] * recip;
      pb <= din.q[Q_W-1:X_W] * recip;
      st2 <= st1;
      f <= fsum[Q_W+31:32];
      st3 <= st2;
      p00 <= st2.mag[28:0] * f[20:0];
      p01 <= st2.mag[28:0] * f[41:21];
      p10 <= st2.mag[56:29] * f[20:0];
      p11 <= st2.mag[56:29] * f[41:21];
      st4 <= st4_next;
      st5 <= st5_next;
    end
  end

  assign dout = st5;

endmodule

// ----- rtl/bessel_j0_power_series.sv -----
// J0(x) by a 30-term power series: a chain of term cells, one request per cycle;
// registers: input square, 29 cells of 5 stages each, output register;
// the whole chain holds while a result waits on m_tready.
module bessel_j0_power_series (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] arg_x, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [35:0] bessel_value, [36] saturated, rest zero
);
  import bj0_pkg::*;

`include "bessel_j0_power_series_assert.svh"

  bj0_item_t chain [NUM_CELLS+1];
  bj0_item_t head;
  logic en;
  logic signed [OUT_W-1:0] val;
  logic oclip;
  logic signed [SUM_W-1:0] fs;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid <= s_tvalid;
      head.q <= s_tdata[X_W-1:0] * s_tdata[X_W-1:0];
      head.mag <= MAG_W'(64'd1 << 30);
      head.sum <= SUM_W'(64'd1 << 30);
      head.clip <= 1'b0;
    end
  end

  assign chain[0] = head;

  for (genvar gj = 1; gj <= NUM_CELLS; gj++) begin : g_term
    localparam logic [63:0] JSQ = 64'(gj * gj);
    localparam logic [R_W-1:0] RJ = R_W'(((64'd1 << 32) + JSQ / 2) / JSQ);
    localparam logic ODD = 1'(gj % 2);
    bj0_cell u_term (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .recip (RJ),
      .odd   (ODD),
      .din   (chain[gj-1]),
      .dout  (chain[gj])
    );
  end

  always_comb begin
    fs = chain[NUM_CELLS].sum;
    if (fs > SUM_W'(OUT_MAX)) begin
      val = OUT_MAX;
      oclip = 1'b1;
    end else if (fs < SUM_W'(OUT_MIN)) begin
      val = OUT_MIN;
      oclip = 1'b1;
    end else begin
      val = fs[OUT_W-1:0];
      oclip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= chain[NUM_CELLS].valid;
      m_tdata <= {3'b000, chain[NUM_CELLS].clip | oclip, val};
    end
  end

  `BJ0_ASSERT_NEXT(a_stall_hold, !en, $stable(chain[NUM_CELLS].valid), "chain moved in stall")
  `BJ0_ASSERT_NEXT(a_out_load, en && chain[NUM_CELLS].valid, m_tvalid, "result dropped")
  `BJ0_ASSERT_NOW(a_out_src, $rose(m_tvalid), $past(chain[NUM_CELLS].valid), "spurious result")

endmodule

// ----- test/testbench.sv -----
// J0(x) power-series testbench: directed, random, back-pressure and streaming tests.
module testbench;

  import bj0_pkg::*;

  localparam int LATENCY = 147;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } j0_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  j0_result_t expected_j0[$];
  int  n_args = 0;
  int  n_results = 0;
  int  n_sat = 0;
  int  n_errors = 0;
  int  quiet_cycles = 0;
  bit  idling_on = 1'b1;
  bit  long_hold_req = 1'b0;
  int  hold_left = 0;

  bessel_j0_power_series u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Truncated series, magnitude and sign kept apart, Q27.30 inside.
  function automatic j0_result_t j0_series(input logic [X_W-1:0] x);
    logic [127:0] q;
    logic [127:0] recip;
    logic [127:0] fac;
    logic [127:0] prod;
    logic [127:0] mag;
    logic [127:0] dsq;
    longint       sum;
    longint       smag;
    longint       inner_max;
    longint       inner_min;
    longint       out_max;
    longint       out_min;
    logic         clip;
    j0_result_t   res;
    inner_max = (64'sd1 <<< 57) - 1;
    inner_min = -inner_max - 1;
    out_max = (64'sd1 <<< 35) - 1;
    out_min = -out_max - 1;
    q = {107'b0, x} * {107'b0, x};
    mag = 128'd1 << 30;
    sum = 64'sd1 <<< 30;
    clip = 1'b0;
    for (int j = 1; j < NUM_TERMS; j++) begin
      dsq = 128'(j * j);
      recip = ((128'd1 << 32) + dsq / 2) / dsq;
      fac = (q * recip + (128'd1 << 31)) >> 32;
      prod = (mag * fac + (128'd1 << 33)) >> 34;
      if (prod > {71'b0, INNER_MAX}) begin
        mag = {71'b0, INNER_MAX};
        clip = 1'b1;
      end else begin
        mag = prod;
      end
      smag = longint'(mag[63:0]);
      if (j % 2 == 1) begin
        if (sum < inner_min + smag) begin
          sum = inner_min;
          clip = 1'b1;
        end else begin
          sum = sum - smag;
        end
      end else begin
        if (sum > inner_max - smag) begin
          sum = inner_max;
          clip = 1'b1;
        end else begin
          sum = sum + smag;
        end
      end
    end
    if (sum > out_max) begin
      sum = out_max;
      clip = 1'b1;
    end else if (sum < out_min) begin
      sum = out_min;
      clip = 1'b1;
    end
    res.value = sum[OUT_W-1:0];
    res.sat = clip;
    return res;
  endfunction

  task automatic send_arg(input logic [X_W-1:0] x);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, x};
    do @(posedge clk); while (!s_tready);
    expected_j0.push_back(j0_series(x));
    n_args++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [X_W-1:0] rand_arg();
    case ($urandom_range(0, 3))
      0: return X_W'($urandom_range(0, 2097151));
      1: return X_W'($urandom_range(20 << 16, 24 << 16));
      default: return X_W'($urandom_range(0, 20 << 16));
    endcase
  endfunction

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    logic       ready_nxt;
    j0_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_j0.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          n_errors++;
        end else begin
          exp_r = expected_j0.pop_front();
          if (m_tdata[35:0] !== exp_r.value) begin
            $error("bessel_value: expected %h, got %h", exp_r.value, m_tdata[35:0]);
            n_errors++;
          end
          if (m_tdata[36] !== exp_r.sat) begin
            $error("saturated: expected %b, got %b", exp_r.sat, m_tdata[36]);
            n_errors++;
          end
          if (exp_r.sat) n_sat++;
        end
      end
      ready_nxt = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        ready_nxt = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 4);
        ready_nxt = 1'b0;
      end
      m_tready <= ready_nxt;
    end
  end

  // Watchdog on cycles with no request moving on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_j0.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_directed();
    logic [X_W-1:0] args[$];
    args = '{21'd0, 21'd1, 21'd2097151, 21'd65536, 21'd131072, 21'd157601,
             21'd1441792, 21'd1448000, 21'd1500000, 21'd1507328, 21'd1540096,
             21'd1572864, 21'd1638400, 21'd1966080, 21'd2031616, 21'd1048576,
             21'h155555, 21'h0AAAAA, 21'd32768, 21'd361793};
    foreach (args[i]) send_arg(args[i]);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_arg(rand_arg());
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    repeat (300) send_arg(rand_arg());
  endtask

  task automatic test_streaming();
    idling_on = 1'b0;
    repeat (200) send_arg(rand_arg());
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_streaming();
    while (expected_j0.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d arguments sent, %0d results checked, %0d of them saturated",
             n_args, n_results, n_sat);
    $display("covered: field extremes, slow convergence near 22, clipping, long stall");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
